// ===== rtl/tsos_pkg.sv =====
// Shared types and constants for the timed three-output sequencer.
`timescale 1ns / 1ps

package tsos_pkg;

  // Width of each timing register (milliseconds).
  localparam int TIME_W = 20;

  // Reset values of the timing registers.
  localparam logic [TIME_W-1:0] FIRST_ON_RESET     = 20'd15000;
  localparam logic [TIME_W-1:0] SECOND_START_RESET = 20'd5000;
  localparam logic [TIME_W-1:0] SECOND_ON_RESET    = 20'd25000;
  localparam logic [TIME_W-1:0] THIRD_ON_RESET     = 20'd40000;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ON     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_START = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_ON    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_THIRD_ON     = 2'd3;

  // Input item kinds and the start/stop button.
  localparam logic KIND_TICK   = 1'b0;
  localparam logic KIND_BUTTON = 1'b1;
  localparam logic [1:0] BTN_AUTO = 2'd3;

  // Output bit positions.
  localparam int OUT_FIRST  = 0;
  localparam int OUT_SECOND = 1;
  localparam int OUT_THIRD  = 2;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_FIRST  = 2'd1,
    PH_SECOND = 2'd2,
    PH_THIRD  = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_MANUAL   = 3'd1,
    EV_START    = 3'd2,
    EV_STOP     = 3'd3,
    EV_STAGE    = 3'd4,
    EV_COMPLETE = 3'd5
  } event_t;

endpackage

// ===== rtl/tsos_if.sv =====
// Channel interfaces: input item and result item, each with valid/ready.
`timescale 1ns / 1ps

interface tsos_item_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [1:0] button_index;

  modport source (output valid, output kind, output button_index, input ready);
  modport sink   (input valid, input kind, input button_index, output ready);
endinterface

interface tsos_result_if;
  logic       valid;
  logic       ready;
  logic       out_first;
  logic       out_second;
  logic       out_third;
  logic       auto_active;
  logic [1:0] phase_now;
  logic [2:0] event_code;

  modport source (
    output valid, output out_first, output out_second, output out_third,
    output auto_active, output phase_now, output event_code, input ready
  );
  modport sink (
    input valid, input out_first, input out_second, input out_third,
    input auto_active, input phase_now, input event_code, output ready
  );
endinterface

// ===== rtl/timed_three_output_sequencer_core.sv =====
// Top level of the timed three-output sequencer.
`timescale 1ns / 1ps

// Timed three-output sequencer. Each input transaction is a one-millisecond tick
// (kind 0) or a button press (kind 1). Buttons 0 to 2 toggle outputs 0 to 2;
// button 3 starts or stops the automatic cycle. The cycle runs output 0 for
// first_on_ticks, switches output 1 on after second_start_ticks, runs output 1
// alone for second_on_ticks if it is on, then a third phase of third_on_ticks,
// and stops with all outputs off. Every input transaction yields exactly one
// result transaction with the state after that item and an event code. Rate:
// one transaction per clock while result.ready is high; the result is loaded
// into the output register on acceptance, and item.ready stays high while
// that register is empty or is being taken in the same cycle, so the block
// sustains one item per cycle under no back-pressure. The elapsed counter is
// COUNT_BITS wide and saturates; the four timing registers are written through
// cfg_we/cfg_index/cfg_data and take effect at once (write only while idle).
module timed_three_output_sequencer_core #(
  parameter int COUNT_BITS = 20
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [tsos_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tsos_pkg::TIME_W-1:0]       cfg_data,
  tsos_item_if.sink                         item,
  tsos_result_if.source                     result
);

  // Compare width covers both the counter and the timing registers.
  localparam int CMP_W = (COUNT_BITS > tsos_pkg::TIME_W) ? COUNT_BITS : tsos_pkg::TIME_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  // Timing registers.
  logic [tsos_pkg::TIME_W-1:0] first_on;
  logic [tsos_pkg::TIME_W-1:0] second_start;
  logic [tsos_pkg::TIME_W-1:0] second_on;
  logic [tsos_pkg::TIME_W-1:0] third_on;

  // Sequencer state.
  logic [2:0]        output_bits, output_bits_next;
  logic              auto_flag, auto_flag_next;
  tsos_pkg::phase_t  phase, phase_next;
  logic [COUNT_BITS-1:0] elapsed, elapsed_next;
  tsos_pkg::event_t  ev_next;

  logic accept;
  logic is_tick;
  logic running;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic hit_first, hit_start, hit_second, hit_third;

  // ---------------------------------------------------------------------------
  // Handshake: the output register holds one result; accept a new transaction
  // whenever that register is empty or drains in this cycle.
  // ---------------------------------------------------------------------------
  assign item.ready = !result.valid || result.ready;
  assign accept     = item.valid && item.ready;

  // ---------------------------------------------------------------------------
  // Configuration writes.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      first_on     <= tsos_pkg::FIRST_ON_RESET;
      second_start <= tsos_pkg::SECOND_START_RESET;
      second_on    <= tsos_pkg::SECOND_ON_RESET;
      third_on     <= tsos_pkg::THIRD_ON_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tsos_pkg::CFG_FIRST_ON:     first_on     <= cfg_data;
        tsos_pkg::CFG_SECOND_START: second_start <= cfg_data;
        tsos_pkg::CFG_SECOND_ON:    second_on    <= cfg_data;
        tsos_pkg::CFG_THIRD_ON:     third_on     <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Tick timing: advance the counter (saturating) first, then compare.
  // ---------------------------------------------------------------------------
  assign is_tick = (item.kind == tsos_pkg::KIND_TICK);
  assign running = auto_flag && (phase != tsos_pkg::PH_IDLE);
  assign cnt_inc = (elapsed == CNT_MAX) ? elapsed : elapsed + 1'b1;

  assign hit_first  = CMP_W'(cnt_inc) >= CMP_W'(first_on);
  assign hit_start  = CMP_W'(cnt_inc) >= CMP_W'(second_start);
  assign hit_second = CMP_W'(cnt_inc) >= CMP_W'(second_on);
  assign hit_third  = CMP_W'(cnt_inc) >= CMP_W'(third_on);

  // Next-state logic.
  always_comb begin
    output_bits_next = output_bits;
    auto_flag_next   = auto_flag;
    phase_next       = phase;
    elapsed_next     = elapsed;
    if (is_tick) begin
      if (running) begin
        elapsed_next = cnt_inc;
        unique case (phase)
          tsos_pkg::PH_FIRST: begin
            if (hit_first) begin
              // Output 0 done: go to output-1-alone phase only if it is on.
              output_bits_next[tsos_pkg::OUT_FIRST] = 1'b0;
              phase_next   = output_bits[tsos_pkg::OUT_SECOND] ?
                             tsos_pkg::PH_SECOND : tsos_pkg::PH_THIRD;
              elapsed_next = '0;
            end else if (hit_start && !output_bits[tsos_pkg::OUT_SECOND]) begin
              output_bits_next[tsos_pkg::OUT_SECOND] = 1'b1;
            end
          end
          tsos_pkg::PH_SECOND: begin
            if (hit_second) begin
              output_bits_next[tsos_pkg::OUT_SECOND] = 1'b0;
              phase_next   = tsos_pkg::PH_THIRD;
              elapsed_next = '0;
            end
          end
          tsos_pkg::PH_THIRD: begin
            if (hit_third) begin
              output_bits_next = '0;
              auto_flag_next   = 1'b0;
              phase_next       = tsos_pkg::PH_IDLE;
              elapsed_next     = '0;
            end
          end
          default: ;
        endcase
      end
    end else if (item.button_index != tsos_pkg::BTN_AUTO) begin
      output_bits_next = output_bits ^ (3'b001 << item.button_index);
    end else if (auto_flag) begin
      // Stop: drop everything.
      output_bits_next = '0;
      auto_flag_next   = 1'b0;
      phase_next       = tsos_pkg::PH_IDLE;
      elapsed_next     = '0;
    end else begin
      // Start: only output 0 changes.
      output_bits_next[tsos_pkg::OUT_FIRST] = 1'b1;
      auto_flag_next = 1'b1;
      phase_next     = tsos_pkg::PH_FIRST;
      elapsed_next   = '0;
    end
  end

  // Event code for the result.
  always_comb begin
    ev_next = tsos_pkg::EV_NONE;
    if (is_tick) begin
      if (running) begin
        unique case (phase)
          tsos_pkg::PH_FIRST:
            if (hit_first || (hit_start && !output_bits[tsos_pkg::OUT_SECOND])) begin
              ev_next = tsos_pkg::EV_STAGE;
            end
          tsos_pkg::PH_SECOND:
            if (hit_second) begin
              ev_next = tsos_pkg::EV_STAGE;
            end
          tsos_pkg::PH_THIRD:
            if (hit_third) begin
              ev_next = tsos_pkg::EV_COMPLETE;
            end
          default: ;
        endcase
      end
    end else if (item.button_index != tsos_pkg::BTN_AUTO) begin
      ev_next = tsos_pkg::EV_MANUAL;
    end else if (auto_flag) begin
      ev_next = tsos_pkg::EV_STOP;
    end else begin
      ev_next = tsos_pkg::EV_START;
    end
  end

  // State registers: advance only on an accepted transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      output_bits <= '0;
      auto_flag   <= 1'b0;
      phase       <= tsos_pkg::PH_IDLE;
      elapsed     <= '0;
    end else if (accept) begin
      output_bits <= output_bits_next;
      auto_flag   <= auto_flag_next;
      phase       <= phase_next;
      elapsed     <= elapsed_next;
    end
  end

  // Output register: valid is control, payload loads on accept.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (accept) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result.out_first   <= output_bits_next[tsos_pkg::OUT_FIRST];
      result.out_second  <= output_bits_next[tsos_pkg::OUT_SECOND];
      result.out_third   <= output_bits_next[tsos_pkg::OUT_THIRD];
      result.auto_active <= auto_flag_next;
      result.phase_now   <= phase_next;
      result.event_code  <= ev_next;
    end
  end

`ifndef SYNTH
  // The running flag and the phase always agree.
  a_auto_phase: assert property (@(posedge clk) disable iff (rst)
    auto_flag == (phase != tsos_pkg::PH_IDLE))
    else $error("auto flag and phase disagree");

  // The counter rests at zero while idle.
  a_idle_count: assert property (@(posedge clk) disable iff (rst)
    (phase == tsos_pkg::PH_IDLE) |-> (elapsed == '0))
    else $error("elapsed count nonzero while idle");

  // From idle the cycle can only enter the first phase.
  a_idle_exit: assert property (@(posedge clk) disable iff (rst)
    (phase == tsos_pkg::PH_IDLE) |=>
      (phase == tsos_pkg::PH_IDLE || phase == tsos_pkg::PH_FIRST))
    else $error("illegal exit from idle");

  // A completed cycle reports all outputs off and idle.
  a_complete_off: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.event_code == tsos_pkg::EV_COMPLETE) |->
      (!result.out_first && !result.out_second && !result.out_third &&
       !result.auto_active && result.phase_now == tsos_pkg::PH_IDLE))
    else $error("completion result with outputs still on");

  // Every accepted transaction leaves a result in the output register.
  a_accept_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> result.valid)
    else $error("accepted item produced no result");
`endif

endmodule
